// ===== sv/jac3_pkg.sv =====
// Shared types and constants of the seven-point Jacobi sweep.
`timescale 1ns / 1ps
package jac3_pkg;
  localparam int MAX_X = 64;
  localparam int MAX_Y = 64;
  localparam int MAX_Z = 1024;
  localparam int RING_LEN = 2 * MAX_X * MAX_Y + 2 * MAX_X + 2;
  localparam int AW = $clog2(RING_LEN);
  localparam int SLOT_W = 33;

  localparam logic [1:0] REG_SIZE_X = 2'd0;
  localparam logic [1:0] REG_SIZE_Y = 2'd1;
  localparam logic [1:0] REG_SIZE_Z = 2'd2;

  typedef struct packed {
    logic signed [31:0] node_value;
    logic               is_padding;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] new_value;
    logic               was_updated;
    logic               last_of_box;
    logic [62:0]        residual_sum;
  } out_beat_t;
endpackage

// ===== sv/jac3_ram.sv =====
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module jac3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write one word, read one word a cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== sv/jacobi_3d_seven_point_sweep.sv =====
// Top level of the seven-point Jacobi sweep over a streamed box.
//
//  channel | signals                       | direction
//  in      | in_valid in_ready in_data     | node beats in, raster order
//  out     | out_valid out_ready out_data  | result beats out
//  cfg     | cfg_we cfg_index cfg_data     | size register writes
//
// An item whose delayed slot holds no node returns to idle after the center
// read, a pass-through node goes on to the output state, and an interior node
// also has the single read port of the ring memory fetch the six neighbors one
// per cycle, then multiply, saturate, square and add run as states of their own.
// Reset and every register write start a clearing pass over all RING_LEN
// (8322) words of the ring memory; no beat is taken during it.
// A stalled result holds the block in its output state until taken.
`timescale 1ns / 1ps
module jacobi_3d_seven_point_sweep (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  jac3_pkg::in_beat_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output jac3_pkg::out_beat_t out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [10:0]        cfg_data
);
  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_CTR, S_NB, S_MUL, S_SQ, S_ACC, S_ACCW, S_OUT
  } state_t;

  localparam int AW_L = jac3_pkg::AW;
  localparam logic [AW_L-1:0] LAST_ADDR = AW_L'(jac3_pkg::RING_LEN - 1);
  localparam logic [65:0] RES_MAX = {3'b000, {63{1'b1}}};
  localparam logic signed [17:0] RECIP = 18'sd43691;

  state_t state;
  logic [6:0]  size_x, size_y;
  logic [10:0] size_z;
  logic [AW_L-1:0] wp, clr_addr;
  logic [5:0]  out_x, out_y;
  logic [9:0]  out_z;
  logic [62:0] acc;
  logic [2:0]  k;
  logic signed [31:0] old_v, new_v;
  logic signed [34:0] sum;
  logic signed [52:0] prod;
  logic [65:0] sq;
  logic        upd;

  // clamp the sizes
  logic [6:0]  nx, ny;
  logic [10:0] nz;
  logic [12:0] plane, delay;
  always_comb begin
    nx = (size_x < 7'd3) ? 7'd3 : (size_x > 7'(jac3_pkg::MAX_X)) ? 7'(jac3_pkg::MAX_X) : size_x;
    ny = (size_y < 7'd3) ? 7'd3 : (size_y > 7'(jac3_pkg::MAX_Y)) ? 7'(jac3_pkg::MAX_Y) : size_y;
    nz = (size_z < 11'd3) ? 11'd3 :
         (size_z > 11'(jac3_pkg::MAX_Z)) ? 11'(jac3_pkg::MAX_Z) : size_z;
    plane = 13'(nx) * 13'(ny);
    delay = plane + 13'(nx) + 13'd1;
  end

  // pick the distance back from the write pointer
  logic [2:0]  sel;
  logic [13:0] span;
  logic [14:0] back_raw;
  logic [AW_L-1:0] raddr;
  always_comb begin
    sel = (state == S_CTR) ? 3'd0 : k + 3'd1;
    case (sel)
      3'd0:    span = 14'(delay) - 14'd1;
      3'd1:    span = 14'(delay) + 14'd1;
      3'd2:    span = 14'(plane) + 14'd1;
      3'd3:    span = 14'(delay) + 14'(nx);
      3'd4:    span = 14'(nx) + 14'd1;
      default: span = 14'(delay) + 14'(plane);
    endcase
    if (state == S_IDLE) span = 14'(delay);
    if (15'(wp) >= 15'(span)) back_raw = 15'(wp) - 15'(span);
    else back_raw = 15'(wp) + 15'(jac3_pkg::RING_LEN) - 15'(span);
    raddr = back_raw[AW_L-1:0];
  end

  logic in_fire;
  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;

  logic               we;
  logic [AW_L-1:0]    waddr;
  logic [jac3_pkg::SLOT_W-1:0] wdata, rdata;
  always_comb begin
    we    = (state == S_CLR) || in_fire;
    waddr = (state == S_CLR) ? clr_addr : wp;
    wdata = (state == S_CLR || in_data.is_padding) ? '0 : {1'b1, in_data.node_value};
  end

  jac3_ram #(.WIDTH(jac3_pkg::SLOT_W), .DEPTH(jac3_pkg::RING_LEN)) u_ring (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // position tests
  logic interior, last;
  always_comb begin
    interior = out_x != 6'd0 && (7'(out_x) + 7'd1 < nx) &&
               out_y != 6'd0 && (7'(out_y) + 7'd1 < ny) &&
               out_z != 10'd0 && (11'(out_z) + 11'd1 < nz);
    last = (7'(out_x) + 7'd1 >= nx) && (7'(out_y) + 7'd1 >= ny) &&
           (11'(out_z) + 11'd1 >= nz);
  end

  // quotient, saturation, change and running sum
  logic signed [34:0] qv;
  logic signed [31:0] q_sat;
  logic signed [32:0] d;
  logic [32:0] absd;
  logic [65:0] tot;
  logic [AW_L-1:0] wp_inc;
  always_comb begin
    qv = prod[52:18];
    if (qv > 35'sd2147483647) q_sat = 32'sh7fffffff;
    else if (qv < -35'sd2147483648) q_sat = 32'sh80000000;
    else q_sat = qv[31:0];
    d = {new_v[31], new_v} - {old_v[31], old_v};
    absd = d[32] ? 33'(-d) : 33'(d);
    tot = {3'b000, acc} + sq;
    wp_inc = (wp == LAST_ADDR) ? '0 : wp + AW_L'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      clr_addr <= '0;
      size_x <= 7'd64;
      size_y <= 7'd64;
      size_z <= 11'd64;
      wp <= '0;
      out_x <= '0;
      out_y <= '0;
      out_z <= '0;
      acc <= '0;
      k <= '0;
      out_valid <= 1'b0;
    end else if (cfg_we) begin
      // take the write and restart the stream
      unique case (cfg_index)
        jac3_pkg::REG_SIZE_X: size_x <= cfg_data[6:0];
        jac3_pkg::REG_SIZE_Y: size_y <= cfg_data[6:0];
        jac3_pkg::REG_SIZE_Z: size_z <= cfg_data;
        default: ;
      endcase
      state <= S_CLR;
      clr_addr <= '0;
      wp <= '0;
      out_x <= '0;
      out_y <= '0;
      out_z <= '0;
      acc <= '0;
    end else begin
      // drop a taken beat unless the output state presents the next one
      if (out_valid && out_ready && state != S_OUT) out_valid <= 1'b0;
      unique case (state)
        S_CLR: begin
          clr_addr <= clr_addr + AW_L'(1);
          if (clr_addr == LAST_ADDR) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_fire) state <= S_CTR;
        end
        S_CTR: begin
          old_v <= rdata[31:0];
          new_v <= rdata[31:0];
          upd <= interior;
          sum <= '0;
          k <= '0;
          if (!rdata[32]) begin
            wp <= wp_inc;
            state <= S_IDLE;
          end else if (interior) begin
            state <= S_NB;
          end else begin
            state <= S_OUT;
          end
        end
        S_NB: begin
          // add one neighbor a cycle
          sum <= sum + {{3{rdata[31]}}, rdata[31:0]};
          k <= k + 3'd1;
          if (k == 3'd5) state <= S_MUL;
        end
        S_MUL: begin
          prod <= sum * RECIP;
          state <= S_SQ;
        end
        S_SQ: begin
          new_v <= q_sat;
          state <= S_ACC;
        end
        S_ACC: begin
          sq <= 66'(absd) * 66'(absd);
          state <= S_ACCW;
        end
        S_ACCW: begin
          // add the squared change with saturation
          acc <= (tot > RES_MAX) ? RES_MAX[62:0] : tot[62:0];
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            out_data.new_value <= new_v;
            out_data.was_updated <= upd;
            out_data.last_of_box <= last;
            out_data.residual_sum <= last ? acc : '0;
            if (last) begin
              out_x <= '0;
              out_y <= '0;
              out_z <= '0;
              acc <= '0;
            end else if (7'(out_x) + 7'd1 < nx) begin
              out_x <= out_x + 6'd1;
            end else begin
              out_x <= '0;
              if (7'(out_y) + 7'd1 < ny) out_y <= out_y + 6'd1;
              else begin
                out_y <= '0;
                out_z <= out_z + 10'd1;
              end
            end
            wp <= wp_inc;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule

// ===== tb/jac3_sweep_checker.sv =====
// Checker for the Jacobi sweep: predicts result beats and compares them.
`timescale 1ns / 1ps
module jac3_sweep_checker
  import jac3_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_beat_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_beat_t out_data,
  input  logic      cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [10:0] cfg_data,
  output int        errors,
  output int        pending
);
  localparam logic [62:0] RES_CAP = '1;

  logic [6:0]  dim_x, dim_y;
  logic [10:0] dim_z;
  logic [31:0] hist_val [RING_LEN];
  logic        hist_node [RING_LEN];
  int unsigned wr_ptr, pos_x, pos_y, pos_z;
  logic [62:0] box_residual;
  out_beat_t   sweep_q [$];

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    if (v < 3) return 3;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic longint tap(int unsigned span);
    return longint'(signed'(hist_val[(wr_ptr + RING_LEN - span) % RING_LEN]));
  endfunction

  task automatic clear_stream();
    for (int i = 0; i < RING_LEN; i++) begin
      hist_val[i] = '0;
      hist_node[i] = 1'b0;
    end
    wr_ptr = 0;
    pos_x = 0;
    pos_y = 0;
    pos_z = 0;
    box_residual = '0;
  endtask

  // Push one node beat into the delay line and queue the result it releases.
  task automatic predict_node(in_beat_t b);
    int unsigned nx, ny, nz, plane, delay, ctr;
    longint old_v, new_v, sum, q, d;
    logic [63:0] mag, sq;
    logic inner, last;
    out_beat_t r;
    nx = clamp_dim(dim_x, MAX_X);
    ny = clamp_dim(dim_y, MAX_Y);
    nz = clamp_dim(dim_z, MAX_Z);
    plane = nx * ny;
    delay = plane + nx + 1;
    hist_val[wr_ptr] = b.is_padding ? 32'd0 : b.node_value;
    hist_node[wr_ptr] = !b.is_padding;
    ctr = (wr_ptr + RING_LEN - delay) % RING_LEN;
    if (hist_node[ctr]) begin
      old_v = longint'(signed'(hist_val[ctr]));
      new_v = old_v;
      inner = pos_x > 0 && pos_x + 1 < nx && pos_y > 0 && pos_y + 1 < ny &&
              pos_z > 0 && pos_z + 1 < nz;
      if (inner) begin
        sum = tap(delay - 1) + tap(delay + 1) + tap(plane + 1) + tap(delay + nx) +
              tap(nx + 1) + tap(delay + plane);
        q = (sum * 43691) >>> 18;
        if (q > 64'sd2147483647) q = 64'sd2147483647;
        if (q < -64'sd2147483648) q = -64'sd2147483648;
        new_v = q;
        d = new_v - old_v;
        mag = (d < 0) ? 64'(-d) : 64'(d);
        sq = mag * mag;
        if (sq > {1'b0, RES_CAP} - {1'b0, box_residual}) box_residual = RES_CAP;
        else box_residual = box_residual + sq[62:0];
      end
      last = pos_x + 1 >= nx && pos_y + 1 >= ny && pos_z + 1 >= nz;
      r.new_value = new_v[31:0];
      r.was_updated = inner;
      r.last_of_box = last;
      r.residual_sum = last ? box_residual : '0;
      sweep_q.push_back(r);
      // advance the raster position of the outgoing node
      if (last) begin
        pos_x = 0;
        pos_y = 0;
        pos_z = 0;
        box_residual = '0;
      end else if (pos_x + 1 < nx) begin
        pos_x++;
      end else begin
        pos_x = 0;
        if (pos_y + 1 < ny) pos_y++;
        else begin
          pos_y = 0;
          pos_z++;
        end
      end
    end
    wr_ptr = (wr_ptr + 1) % RING_LEN;
  endtask

  // Compare outgoing beats, then track register writes and incoming beats.
  always @(posedge clk) begin
    out_beat_t want;
    if (rst) begin
      dim_x = 7'd64;
      dim_y = 7'd64;
      dim_z = 11'd64;
      clear_stream();
      sweep_q.delete();
      errors = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (sweep_q.size() == 0) begin
          if (errors < 10) $display("checker: result beat with none expected: %p", out_data);
          errors++;
        end else begin
          want = sweep_q.pop_front();
          if (out_data.new_value !== want.new_value ||
              out_data.was_updated !== want.was_updated ||
              out_data.last_of_box !== want.last_of_box ||
              out_data.residual_sum !== want.residual_sum) begin
            if (errors < 10)
              $display("checker: mismatch at %0t exp %p got %p", $realtime, want, out_data);
            errors++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_SIZE_X: dim_x = cfg_data[6:0];
          REG_SIZE_Y: dim_y = cfg_data[6:0];
          REG_SIZE_Z: dim_z = cfg_data;
          default: ;
        endcase
        clear_stream();
      end else if (in_valid && in_ready) begin
        predict_node(in_data);
      end
    end
    pending = sweep_q.size();
  end
endmodule

// ===== tb/tb_jacobi_3d_seven_point_sweep.sv =====
// Stimulus and verdict for the seven-point Jacobi sweep testbench.
`timescale 1ns / 1ps
module tb_jacobi_3d_seven_point_sweep;
  import jac3_pkg::*;

  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam int RUN_LIMIT = 4000000;
  localparam int BOX_TARGET = 60;
  localparam logic [31:0] VAL_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] VAL_MIN = 32'h8000_0000;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_beat_t out_data;
  logic      cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [10:0] cfg_data = '0;
  int        errors;
  int        pending;

  int        burst_left = 0;
  int        run_cycles = 0;
  logic [31:0] rx_cycle = '0;
  int        rx_mode = 0;
  int        hold_cnt = 0;
  logic      hold_req = 1'b0;
  logic      hold_taken = 1'b0;
  int        nx, ny, nz;

  always begin
    #4 clk = 1'b1;
    #4 clk = 0;
  end

  jacobi_3d_seven_point_sweep u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  jac3_sweep_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  // Stall the result side: one long hold-off on request, else a shifting pattern.
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle[5:0] == 0) rx_mode <= $urandom_range(0, 3);
    if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ready <= 1'b0;
    end else if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_cnt <= 1500;
      out_ready <= 1'b0;
    end else begin
      case (rx_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= (rx_cycle[2:0] < 5);
      endcase
    end
  end

  // Drop the run if it hangs.
  always @(posedge clk) begin
    run_cycles <= run_cycles + 1;
    if (run_cycles > RUN_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic int clamp_dim(int v, int hi);
    if (v < 3) return 3;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return VAL_MAX;
      1: return VAL_MIN;
      2: return 32'($urandom_range(0, 2000)) - 32'd1000;
      default: return $urandom;
    endcase
  endfunction

  // Offer one beat; bursts of random length with random gaps between them.
  task automatic send(input logic [31:0] v, input logic pad);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data <= '{node_value: v, is_padding: pad};
    do @(posedge clk); while (!in_ready);
    burst_left--;
  endtask

  // Hold the sender until every expected beat is out, then let the block settle.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [10:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_box(input int sx, input int sy, input int sz, input logic spare);
    drain();
    if (spare) write_reg(REG_SPARE, 11'($urandom));
    write_reg(REG_SIZE_X, 11'(sx));
    write_reg(REG_SIZE_Y, 11'(sy));
    write_reg(REG_SIZE_Z, 11'(sz));
    nx = clamp_dim(sx & 127, MAX_X);
    ny = clamp_dim(sy & 127, MAX_Y);
    nz = clamp_dim(sz, MAX_Z);
  endtask

  // Push the delay line far enough to release every queued node.
  task automatic flush_line();
    repeat (nx * ny + nx + 1) send($urandom, 1'b1);
  endtask

  int sx_set [9] = '{0, 3, 5, 9, 3, 7, 127, 10, 4};
  int sy_set [9] = '{0, 3, 4, 3, 127, 5, 3, 8, 4};
  int sz_set [9] = '{0, 3, 6, 3, 3, 4, 2047, 3, 3};

  initial begin
    int sent;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset sizes: a short stream that the next register write drops
    nx = 64;
    ny = 64;
    nz = 64;
    repeat (20) send(pick_value(), 1'b0);

    // smallest box: saturating center both ways, then padding inside a box
    set_box(3, 3, 3, 1'b1);
    for (int i = 0; i < 27; i++) send((i == 13) ? VAL_MIN : VAL_MAX, 1'b0);
    for (int i = 0; i < 27; i++) send((i == 13) ? VAL_MAX : VAL_MIN, 1'b0);
    for (int i = 0; i < 27; i++) begin
      if (i == 5) send(VAL_MAX, 1'b1);
      send(pick_value(), 1'b0);
    end
    flush_line();

    // random boxes over a range of sizes, padding sprinkled in as noise; two oversized boxes get only a partial stream
    for (int p = 0; p < 9; p++) begin
      set_box(sx_set[p], sy_set[p], sz_set[p], p[0]);
      sent = 0;
      if (p == 1) hold_req <= 1'b1;
      if (p == 4 || p == 6) begin
        repeat (BOX_TARGET) send(pick_value(), 1'b0);
      end else begin
        while (sent < BOX_TARGET) begin
          for (int i = 0; i < nx * ny * nz; i++) begin
            if ($urandom_range(0, 99) < 3) send(pick_value(), 1'b1);
            send(pick_value(), 1'b0);
          end
          sent += nx * ny * nz;
          if (p == 0 && sent < BOX_TARGET) drain();
        end
      end
      flush_line();
    end

    drain();
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule

// ===== sim.f =====
sv/jac3_pkg.sv
sv/jac3_ram.sv
sv/jacobi_3d_seven_point_sweep.sv
tb/jac3_sweep_checker.sv
tb/tb_jacobi_3d_seven_point_sweep.sv
